// File: sv/pafd_pkg.sv
// ---------------------------------------------------------------------------
// pafd_pkg
// Shared types and constants of the phase-angle firing delay block: the
// arccos table, the arithmetic limits and the controller/datapath interface.
// ---------------------------------------------------------------------------
package pafd_pkg;

  localparam int unsigned DIV_W   = 27;  // dividend and quotient width
  localparam int unsigned DSR_W   = 20;  // divisor and remainder width
  localparam int unsigned DCNT_W  = $clog2(DIV_W + 1);
  localparam int unsigned TAB_N   = 181;

  localparam logic [15:0] SPEED_LO    = 16'd8000;
  localparam logic [15:0] SPEED_HI    = 16'd18000;
  localparam logic [15:0] SP_OFF      = 16'd2600;
  localparam logic [26:0] SP_GAIN     = 27'd1200;
  localparam logic [7:0]  Q_MAX       = 8'd180;
  localparam logic [14:0] TAB_GAIN    = 15'd7;
  localparam logic [14:0] TAB_OFFSET  = 15'd1000;
  localparam logic [15:0] PERIOD_MIN  = 16'd1600;
  localparam logic [15:0] PERIOD_MAX  = 16'd18000;
  localparam logic [15:0] PULSE_LEAD  = 16'd800;

  // Divisions by constants are done as a multiply by a rounded-up reciprocal.
  // The shifts are chosen so that the result is exact for a 16-bit average
  // and for a 22-bit sum with a sample count of up to 63.
  localparam int unsigned VOLT_SCALE  = 90;
  localparam int unsigned VOLT_SHIFT  = 23;
  localparam logic [16:0] VOLT_RECIP  =
    17'(((1 << VOLT_SHIFT) + VOLT_SCALE - 1) / VOLT_SCALE);
  localparam int unsigned AVG_SHIFT   = 28;

  localparam logic [11:0] ACOS_TAB [0:TAB_N-1] = '{
    12'd0,    12'd149,  12'd211,  12'd259,  12'd299,  12'd335,  12'd367,  12'd397,
    12'd425,  12'd451,  12'd476,  12'd499,  12'd522,  12'd544,  12'd565,  12'd585,
    12'd605,  12'd624,  12'd643,  12'd661,  12'd679,  12'd697,  12'd714,  12'd731,
    12'd747,  12'd763,  12'd779,  12'd795,  12'd810,  12'd826,  12'd841,  12'd855,
    12'd870,  12'd884,  12'd899,  12'd913,  12'd927,  12'd941,  12'd954,  12'd968,
    12'd981,  12'd995,  12'd1008, 12'd1021, 12'd1034, 12'd1047, 12'd1059, 12'd1072,
    12'd1085, 12'd1097, 12'd1110, 12'd1122, 12'd1134, 12'd1146, 12'd1159, 12'd1171,
    12'd1183, 12'd1195, 12'd1207, 12'd1218, 12'd1230, 12'd1242, 12'd1254, 12'd1265,
    12'd1277, 12'd1289, 12'd1300, 12'd1312, 12'd1323, 12'd1335, 12'd1346, 12'd1357,
    12'd1369, 12'd1380, 12'd1391, 12'd1403, 12'd1414, 12'd1425, 12'd1436, 12'd1447,
    12'd1459, 12'd1470, 12'd1481, 12'd1492, 12'd1503, 12'd1514, 12'd1525, 12'd1536,
    12'd1548, 12'd1559, 12'd1570, 12'd1581, 12'd1592, 12'd1603, 12'd1614, 12'd1625,
    12'd1636, 12'd1648, 12'd1659, 12'd1670, 12'd1681, 12'd1692, 12'd1703, 12'd1715,
    12'd1726, 12'd1737, 12'd1748, 12'd1760, 12'd1771, 12'd1782, 12'd1794, 12'd1805,
    12'd1816, 12'd1828, 12'd1839, 12'd1851, 12'd1863, 12'd1874, 12'd1886, 12'd1897,
    12'd1909, 12'd1921, 12'd1933, 12'd1945, 12'd1957, 12'd1969, 12'd1981, 12'd1993,
    12'd2005, 12'd2017, 12'd2030, 12'd2042, 12'd2055, 12'd2067, 12'd2080, 12'd2093,
    12'd2106, 12'd2118, 12'd2132, 12'd2145, 12'd2158, 12'd2171, 12'd2185, 12'd2199,
    12'd2212, 12'd2226, 12'd2240, 12'd2255, 12'd2269, 12'd2284, 12'd2298, 12'd2313,
    12'd2328, 12'd2344, 12'd2359, 12'd2375, 12'd2391, 12'd2408, 12'd2425, 12'd2442,
    12'd2459, 12'd2477, 12'd2495, 12'd2514, 12'd2533, 12'd2553, 12'd2573, 12'd2594,
    12'd2616, 12'd2638, 12'd2662, 12'd2686, 12'd2712, 12'd2740, 12'd2769, 12'd2801,
    12'd2836, 12'd2875, 12'd2921, 12'd2980, 12'd3078
  };

  typedef struct packed {
    logic capture;
    logic eval;
    logic avg_step;
    logic scl_step;
    logic square;
    logic div_start;
    logic lookup;
    logic scale;
    logic load_out;
  } pafd_cmd_t;

  typedef struct packed {
    logic need_avg;
    logic div_busy;
    logic d_zero;
  } pafd_sts_t;

endpackage

// File: sv/pafd_ctrl.sv
// ---------------------------------------------------------------------------
// pafd_ctrl
// Sequencer of the firing delay block: takes one word at a time, steps the
// datapath through averaging, division and table lookup, and owns out_valid.
// ---------------------------------------------------------------------------
module pafd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pafd_pkg::pafd_sts_t sts,
  output pafd_pkg::pafd_cmd_t cmd
);
  import pafd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_AVG,
    S_SCL,
    S_SQUARE,
    S_DIV_Q,
    S_WAIT_Q,
    S_LOOKUP,
    S_SCALE,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.need_avg ? S_AVG : S_EMIT;
      end
      S_AVG: begin
        cmd.avg_step = 1'b1;
        state_nxt    = S_SCL;
      end
      S_SCL: begin
        cmd.scl_step = 1'b1;
        state_nxt    = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = S_DIV_Q;
      end
      S_DIV_Q: begin
        // A zero divisor saturates the quotient, so the division is skipped.
        if (sts.d_zero) begin
          state_nxt = S_LOOKUP;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_WAIT_Q;
        end
      end
      S_WAIT_Q: begin
        if (!sts.div_busy) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EVAL))
    else $error("accepted word did not move the sequencer to evaluation");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !sts.div_busy)
    else $error("divider still busy while the sequencer is idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output register loaded over a word not yet taken");

  a_plain_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && !sts.need_avg) |=> (state_r == S_EMIT))
    else $error("word without averaging did not go straight to output");

endmodule

// File: sv/pafd_dp.sv
// ---------------------------------------------------------------------------
// pafd_dp
// Datapath of the firing delay block: input capture, voltage accumulator,
// reciprocal scaling, quotient divider, arccos lookup and output word.
// ---------------------------------------------------------------------------
module pafd_dp #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 50
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic [15:0]         in_bus_voltage,
  input  logic [15:0]         in_motor_speed,
  input  logic                in_motor_running,
  input  logic                in_fault_present,
  input  logic                in_delay_done,
  input  pafd_pkg::pafd_cmd_t cmd,
  output pafd_pkg::pafd_sts_t sts,
  output logic                out_fire,
  output logic [15:0]         out_timer_period,
  output logic [15:0]         out_pulse_compare,
  output logic                out_period_updated
);
  import pafd_pkg::*;

  localparam logic [5:0]  N_AVG     = 6'(SAMPLES_PER_AVERAGE);
  localparam logic [63:0] AVG_ONE   = 64'd1 << AVG_SHIFT;
  localparam logic [28:0] AVG_RECIP = 29'((AVG_ONE + 64'(SAMPLES_PER_AVERAGE) - 64'd1) /
                                          64'(SAMPLES_PER_AVERAGE));

  logic [15:0] sp_r;
  logic [15:0] volt_r;
  logic [15:0] speed_r;
  logic        run_r, flt_r, done_r;
  logic [21:0] sum_r;
  logic [5:0]  cnt_r;
  logic [21:0] tot_r;
  logic [15:0] avg_r;
  logic [9:0]  scl_r;
  logic [15:0] held_r;
  logic        fire_r, upd_r;

  logic [DIV_W-1:0]  quo_r;
  logic [DSR_W-1:0]  rem_r;
  logic [DSR_W-1:0]  dsr_r;
  logic [DCNT_W-1:0] dcnt_r;

  logic [DSR_W-1:0] d_r;
  logic [DIV_W-1:0] num_r;
  logic [11:0]      ent_r;

  logic        gated;
  logic [21:0] sum_inc;
  logic [5:0]  cnt_inc;
  logic        due;

  logic [50:0] avg_prod;
  logic [32:0] scl_prod;

  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  logic [7:0]  q;
  logic [7:0]  idx;
  logic [14:0] p_raw;
  logic [15:0] p_nxt;

  assign gated = run_r && !flt_r && done_r && (speed_r > SPEED_LO) &&
                 (speed_r < SPEED_HI) && (sp_r != SP_OFF);
  assign sum_inc = sum_r + 22'(volt_r);
  assign cnt_inc = cnt_r + 6'd1;
  assign due     = (cnt_inc >= N_AVG);

  assign sts.need_avg = gated && due;
  assign sts.div_busy = (dcnt_r != '0);
  assign sts.d_zero   = (d_r == '0);

  // The average keeps only its low 16 bits, as the slice below does.
  assign avg_prod = {29'd0, tot_r} * {22'd0, AVG_RECIP};
  assign scl_prod = {17'd0, avg_r} * {16'd0, VOLT_RECIP};

  // One quotient bit per cycle; the dividend shifts out of quo_r as the
  // quotient shifts in.
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_comb begin
    if (d_r == '0) begin
      q = Q_MAX;
    end else if (quo_r > DIV_W'(Q_MAX)) begin
      q = Q_MAX;
    end else begin
      q = quo_r[7:0];
    end
    idx   = Q_MAX - q;
    p_raw = {3'b000, ent_r} * TAB_GAIN + TAB_OFFSET;
    if (16'(p_raw) < PERIOD_MIN) begin
      p_nxt = PERIOD_MIN;
    end else if (16'(p_raw) > PERIOD_MAX) begin
      p_nxt = PERIOD_MAX;
    end else begin
      p_nxt = 16'(p_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      held_r <= '0;
      dcnt_r <= '0;
    end else begin
      if (cfg_wr_en) sp_r <= cfg_wr_data;
      if (cmd.eval && gated) begin
        if (due) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_inc;
          cnt_r <= cnt_inc;
        end
      end
      if (cmd.div_start) begin
        dcnt_r <= DCNT_W'(DIV_W);
      end else if (dcnt_r != '0) begin
        dcnt_r <= dcnt_r - DCNT_W'(1);
      end
      if (cmd.scale) held_r <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      volt_r  <= in_bus_voltage;
      speed_r <= in_motor_speed;
      run_r   <= in_motor_running;
      flt_r   <= in_fault_present;
      done_r  <= in_delay_done;
    end
    if (cmd.eval) begin
      fire_r <= gated;
      upd_r  <= gated && due;
      tot_r  <= sum_inc;
    end
    if (cmd.avg_step) avg_r <= avg_prod[AVG_SHIFT+15:AVG_SHIFT];
    if (cmd.scl_step) scl_r <= scl_prod[VOLT_SHIFT+9:VOLT_SHIFT];
    if (cmd.square) begin
      d_r   <= DSR_W'(scl_r) * DSR_W'(scl_r);
      num_r <= DIV_W'(sp_r) * SP_GAIN;
    end
    if (cmd.div_start) begin
      quo_r <= num_r;
      rem_r <= '0;
      dsr_r <= d_r;
    end else if (dcnt_r != '0) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end
    if (cmd.lookup) ent_r <= ACOS_TAB[idx];
    if (cmd.load_out) begin
      out_fire           <= fire_r;
      out_period_updated <= upd_r;
      out_timer_period   <= fire_r ? held_r : 16'd0;
      out_pulse_compare  <= fire_r ? (held_r - PULSE_LEAD) : 16'd0;
    end
  end

endmodule

// File: sv/phase_angle_firing_delay.sv
// ---------------------------------------------------------------------------
// phase_angle_firing_delay
// Firing delay generator for phase-angle control, one word per zero crossing.
// ---------------------------------------------------------------------------
// An ordinary crossing goes from capture and evaluation straight to the output.
// Every SAMPLES_PER_AVERAGE-th gated crossing also passes averaging, scaling,
// squaring, the 27-step restoring divider for the quotient, table lookup and
// period scaling; a zero divisor skips the divider. One word is taken at a time;
// the next is taken once the sequencer is idle, even while the last output waits.
// Reset (synchronous, active low) clears the setpoint, sum, count and period.
module phase_angle_firing_delay #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 50
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_bus_voltage,
  input  logic [15:0] in_motor_speed,
  input  logic        in_motor_running,
  input  logic        in_fault_present,
  input  logic        in_delay_done,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_fire,
  output logic [15:0] out_timer_period,
  output logic [15:0] out_pulse_compare,
  output logic        out_period_updated
);
  import pafd_pkg::*;

  pafd_cmd_t cmd;
  pafd_sts_t sts;

  pafd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pafd_dp #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_bus_voltage     (in_bus_voltage),
    .in_motor_speed     (in_motor_speed),
    .in_motor_running   (in_motor_running),
    .in_fault_present   (in_fault_present),
    .in_delay_done      (in_delay_done),
    .cmd                (cmd),
    .sts                (sts),
    .out_fire           (out_fire),
    .out_timer_period   (out_timer_period),
    .out_pulse_compare  (out_pulse_compare),
    .out_period_updated (out_period_updated)
  );

endmodule
